### design/fge_pkg.sv
package fge_pkg;

  // Fixed-point format of positions, forces, span and spring constant
  localparam int FRAC_BITS = 16;

  // Datapath widths
  localparam int D_W    = 34;               // signed offset obj - point
  localparam int MAG_W  = 33;               // magnitude of an offset
  localparam int SQ_W   = 68;               // sum of three squared offsets
  localparam int ROOT_W = 34;               // integer square root of SQ_W
  localparam int REM_W  = 37;               // square-root partial remainder
  localparam int DEN_W  = ROOT_W + FRAC_BITS;
  localparam int NUM_W  = 97;               // dividend width
  localparam int Q_W    = 33;               // quotient bits before saturation

  // Generator kinds
  typedef enum logic [1:0] {
    FN_CONST  = 2'd0,
    FN_RADIAL = 2'd1,
    FN_SPRING = 2'd2,
    FN_ANCHOR = 2'd3
  } func_t;

  // Fields that ride along the square-root stages
  typedef struct packed {
    func_t                 func;
    logic [2:0]            fneg;
    logic [2:0][31:0]      fmag;
    logic [2:0]            dpos;
    logic [2:0][MAG_W-1:0] dmag;
    logic [30:0]           span;
    logic [30:0]           spring_k;
    logic                  inrange;
    logic [2:0][31:0]      pres;
  } sq_pl_t;

  // Fields that ride along the divider stages
  typedef struct packed {
    func_t            func;
    logic             applied;
    logic [2:0]       neg;
    logic [2:0]       ovf;
    logic [2:0][31:0] pres;
  } dv_pl_t;

  // Apply a sign to a magnitude and clamp to 32-bit two's complement
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    begin
      if (neg) begin
        c = (m > 64'h8000_0000) ? 64'h8000_0000 : m;
        sat32 = 32'(64'd0 - c);
      end else begin
        sat32 = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      end
    end
  endfunction

endpackage

### design/force_generator_eval_top.sv
// Force generator evaluation pipeline. Each input beat carries one generator
// (kind in in_tuser) and one object position; each output beat carries the
// saturated Q16.16 force contribution and the applied flag in out_tuser.
// One beat is accepted per cycle while the output side takes results; a stall
// on the output freezes the whole pipeline. From acceptance to the output
// register a beat passes three front stages (offset, squares,
// sum), a 34-stage square root retiring one root bit per stage, four stages
// of scaling multiplies, a 33-stage divider retiring one quotient bit per
// stage in three lanes, and the output register.
module force_generator_eval_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obj_x, obj_y, obj_z, point_x, point_y, point_z, force_x, force_y,
  // force_z, span, spring_k, 2 pad bits
  input  logic [351:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // delta_x, delta_y, delta_z
  output logic [95:0]  out_tdata,
  // applied
  output logic         out_tuser
);
  import fge_pkg::*;

  localparam int SQ_N = ROOT_W;   // square-root stages
  localparam int DV_N = Q_W;      // divider stages

  logic en;

  // Whole pipeline advances when the output register is free or drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage A: offsets ----------------
  logic                      a_v_r;
  func_t                     a_func_r;
  logic signed [2:0][D_W-1:0] a_d_r;
  logic [2:0][31:0]          a_f_r;
  logic [30:0]               a_span_r, a_k_r;
  logic [2:0][D_W-1:0]       a_d_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d_nxt[i] = {{2{in_tdata[32*i+31]}}, in_tdata[32*i +: 32]}
                 - {{2{in_tdata[96+32*i+31]}}, in_tdata[96+32*i +: 32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_func_r <= func_t'(in_tuser);
      a_d_r    <= a_d_nxt;
      for (int i = 0; i < 3; i++) a_f_r[i] <= in_tdata[192+32*i +: 32];
      a_span_r <= in_tdata[318:288];
      a_k_r    <= in_tdata[349:319];
    end
  end

  // ---------------- stage B: squares and spring products ----------------
  logic                      b_v_r;
  func_t                     b_func_r;
  logic [2:0][MAG_W-1:0]     b_dmag_r;
  logic [2:0]                b_dpos_r, b_fneg_r;
  logic [2:0][31:0]          b_fmag_r, b_f_r;
  logic [2:0][65:0]          b_sq_r;
  logic [2:0][63:0]          b_kd_r;
  logic [61:0]               b_span2_r;
  logic [30:0]               b_span_r, b_k_r;
  logic [2:0][MAG_W-1:0]     b_dmag_nxt;
  logic [2:0][31:0]          b_fmag_nxt;
  logic [2:0][65:0]          b_sq_nxt;
  logic [2:0][63:0]          b_kd_nxt;
  logic [2:0]                b_dpos_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_dmag_nxt[i] = a_d_r[i][D_W-1] ? MAG_W'(-a_d_r[i]) : MAG_W'(a_d_r[i]);
      b_dpos_nxt[i] = !a_d_r[i][D_W-1] && (a_d_r[i] != '0);
      b_fmag_nxt[i] = a_f_r[i][31] ? 32'(-a_f_r[i]) : a_f_r[i];
      b_sq_nxt[i]   = b_dmag_nxt[i] * b_dmag_nxt[i];
      b_kd_nxt[i]   = b_dmag_nxt[i] * a_k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_func_r  <= a_func_r;
      b_dmag_r  <= b_dmag_nxt;
      b_dpos_r  <= b_dpos_nxt;
      b_fmag_r  <= b_fmag_nxt;
      b_f_r     <= a_f_r;
      for (int i = 0; i < 3; i++) b_fneg_r[i] <= a_f_r[i][31];
      b_sq_r    <= b_sq_nxt;
      b_kd_r    <= b_kd_nxt;
      b_span2_r <= a_span_r * a_span_r;
      b_span_r  <= a_span_r;
      b_k_r     <= a_k_r;
    end
  end

  // ---------------- stage C: squared distance, range test ----------------
  sq_pl_t          c_pl_nxt;
  logic [SQ_W-1:0] c_s2_nxt;

  always_comb begin
    c_s2_nxt = SQ_W'(b_sq_r[0]) + SQ_W'(b_sq_r[1]) + SQ_W'(b_sq_r[2]);
    c_pl_nxt.func     = b_func_r;
    c_pl_nxt.fneg     = b_fneg_r;
    c_pl_nxt.fmag     = b_fmag_r;
    c_pl_nxt.dpos     = b_dpos_r;
    c_pl_nxt.dmag     = b_dmag_r;
    c_pl_nxt.span     = b_span_r;
    c_pl_nxt.spring_k = b_k_r;
    c_pl_nxt.inrange  = (b_span_r != '0) && (c_s2_nxt <= SQ_W'(b_span2_r));
    // constant and plain spring finish here
    for (int i = 0; i < 3; i++) begin
      if (b_func_r == FN_CONST) begin
        c_pl_nxt.pres[i] = b_f_r[i];
      end else begin
        c_pl_nxt.pres[i] = sat32(b_dpos_r[i], b_kd_r[i] >> FRAC_BITS);
      end
    end
  end

  // ---------------- square root: one root bit per stage ----------------
  logic                    sq_v_r    [0:SQ_N];
  sq_pl_t                  sq_pl_r   [0:SQ_N];
  logic [SQ_W-1:0]         sq_rad_r  [0:SQ_N];
  logic [REM_W-1:0]        sq_rem_r  [0:SQ_N];
  logic [ROOT_W-1:0]       sq_root_r [0:SQ_N];
  logic [SQ_W-1:0]         sq_rad_nxt  [1:SQ_N];
  logic [REM_W-1:0]        sq_rem_nxt  [1:SQ_N];
  logic [ROOT_W-1:0]       sq_root_nxt [1:SQ_N];

  always_comb begin
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int j = 0; j < SQ_N; j++) begin
      rem_s = {sq_rem_r[j][REM_W-3:0], sq_rad_r[j][SQ_W-1 -: 2]};
      trial = {1'b0, sq_root_r[j], 2'b01};
      ge    = rem_s >= trial;
      sq_rem_nxt[j+1]  = ge ? (rem_s - trial) : rem_s;
      sq_root_nxt[j+1] = {sq_root_r[j][ROOT_W-2:0], ge};
      sq_rad_nxt[j+1]  = {sq_rad_r[j][SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= SQ_N; j++) sq_v_r[j] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= b_v_r;
      for (int j = 1; j <= SQ_N; j++) sq_v_r[j] <= sq_v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_pl_r[0]   <= c_pl_nxt;
      sq_rad_r[0]  <= c_s2_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      for (int j = 1; j <= SQ_N; j++) begin
        sq_pl_r[j]   <= sq_pl_r[j-1];
        sq_rad_r[j]  <= sq_rad_nxt[j];
        sq_rem_r[j]  <= sq_rem_nxt[j];
        sq_root_r[j] <= sq_root_nxt[j];
      end
    end
  end

  // ---------------- stage E: stretch and falloff distance ----------------
  logic              e_v_r, e_sneg_r;
  sq_pl_t            e_pl_r;
  logic [ROOT_W-1:0] e_dist_r, e_smag_r;
  logic [30:0]       e_left_r;
  logic [ROOT_W-1:0] dist_w, span_w;

  assign dist_w = sq_root_r[SQ_N];
  assign span_w = ROOT_W'(sq_pl_r[SQ_N].span);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= sq_v_r[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_pl_r   <= sq_pl_r[SQ_N];
      e_dist_r <= dist_w;
      e_sneg_r <= dist_w < span_w;
      e_smag_r <= (dist_w < span_w) ? (span_w - dist_w) : (dist_w - span_w);
      e_left_r <= sq_pl_r[SQ_N].span - dist_w[30:0];
    end
  end

  // ---------------- stage F: falloff products, stretch times k ----------------
  logic              f_v_r, f_sneg_r;
  sq_pl_t            f_pl_r;
  logic [ROOT_W-1:0] f_dist_r;
  logic [2:0][62:0]  f_num1_r;
  logic [63:0]       f_sk_r;
  logic [64:0]       f_sk_nxt;

  assign f_sk_nxt = e_smag_r * e_pl_r.spring_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_pl_r   <= e_pl_r;
      f_dist_r <= e_dist_r;
      f_sneg_r <= e_sneg_r;
      f_sk_r   <= f_sk_nxt[63:0];   // product wraps at 64 bits
      for (int i = 0; i < 3; i++) f_num1_r[i] <= e_pl_r.fmag[i] * e_left_r;
    end
  end

  // ---------------- stage G: offset times stretch, two partial products ------
  logic              g_v_r, g_sneg_r;
  sq_pl_t            g_pl_r;
  logic [ROOT_W-1:0] g_dist_r;
  logic [2:0][62:0]  g_num1_r;
  logic [2:0][64:0]  g_plo_r, g_phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_pl_r   <= f_pl_r;
      g_dist_r <= f_dist_r;
      g_sneg_r <= f_sneg_r;
      g_num1_r <= f_num1_r;
      for (int i = 0; i < 3; i++) begin
        g_plo_r[i] <= f_pl_r.dmag[i] * f_sk_r[31:0];
        g_phi_r[i] <= f_pl_r.dmag[i] * f_sk_r[63:32];
      end
    end
  end

  // ---------------- stage H: dividend, divisor, overflow ----------------
  logic [2:0][NUM_W-1:0] h_num_nxt;
  logic [DEN_W-1:0]      h_den_nxt;
  dv_pl_t                h_pl_nxt;
  logic                  h_anchor;

  assign h_anchor = (g_pl_r.func == FN_ANCHOR);

  always_comb begin
    h_den_nxt = h_anchor ? {g_dist_r, {FRAC_BITS{1'b0}}} : DEN_W'(g_pl_r.span);
    h_pl_nxt.func = g_pl_r.func;
    h_pl_nxt.pres = g_pl_r.pres;
    case (g_pl_r.func)
      FN_RADIAL: h_pl_nxt.applied = g_pl_r.inrange;
      FN_ANCHOR: h_pl_nxt.applied = (g_dist_r != '0);
      default:   h_pl_nxt.applied = 1'b1;
    endcase
    for (int i = 0; i < 3; i++) begin
      h_num_nxt[i] = h_anchor ? (NUM_W'(g_plo_r[i]) + (NUM_W'(g_phi_r[i]) << 32))
                              : NUM_W'(g_num1_r[i]);
      h_pl_nxt.ovf[i] = h_num_nxt[i][NUM_W-1:Q_W] >= (NUM_W-Q_W)'(h_den_nxt);
      h_pl_nxt.neg[i] = h_anchor ? (g_pl_r.dpos[i] != g_sneg_r) : g_pl_r.fneg[i];
    end
  end

  // ---------------- divider: one quotient bit per stage, three lanes --------
  logic                  dv_v_r   [0:DV_N];
  dv_pl_t                dv_pl_r  [0:DV_N];
  logic [DEN_W-1:0]      dv_den_r [0:DV_N];
  logic [2:0][NUM_W-1:0] dv_num_r [0:DV_N];
  logic [2:0][Q_W-1:0]   dv_q_r   [0:DV_N];
  logic [2:0][NUM_W-1:0] dv_num_nxt [1:DV_N];
  logic [2:0][Q_W-1:0]   dv_q_nxt   [1:DV_N];

  always_comb begin
    logic [NUM_W-1:0] shd;
    logic             ge;
    for (int j = 0; j < DV_N; j++) begin
      shd = NUM_W'(dv_den_r[j]) << (DV_N - 1 - j);
      for (int i = 0; i < 3; i++) begin
        ge                = dv_num_r[j][i] >= shd;
        dv_num_nxt[j+1][i] = ge ? (dv_num_r[j][i] - shd) : dv_num_r[j][i];
        dv_q_nxt[j+1][i]   = dv_q_r[j][i];
        dv_q_nxt[j+1][i][DV_N-1-j] = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= DV_N; j++) dv_v_r[j] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= g_v_r;
      for (int j = 1; j <= DV_N; j++) dv_v_r[j] <= dv_v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_pl_r[0]  <= h_pl_nxt;
      dv_den_r[0] <= h_den_nxt;
      dv_num_r[0] <= h_num_nxt;
      dv_q_r[0]   <= '0;
      for (int j = 1; j <= DV_N; j++) begin
        dv_pl_r[j]  <= dv_pl_r[j-1];
        dv_den_r[j] <= dv_den_r[j-1];
        dv_num_r[j] <= dv_num_nxt[j];
        dv_q_r[j]   <= dv_q_nxt[j];
      end
    end
  end

  // ---------------- output register ----------------
  dv_pl_t           o_pl;
  logic [2:0][31:0] o_res_nxt;
  logic             out_v_r, out_applied_r;
  logic [95:0]      out_data_r;

  assign o_pl = dv_pl_r[DV_N];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (o_pl.func == FN_CONST || o_pl.func == FN_SPRING) begin
        o_res_nxt[i] = o_pl.pres[i];
      end else if (!o_pl.applied) begin
        o_res_nxt[i] = '0;
      end else begin
        o_res_nxt[i] = sat32(o_pl.neg[i],
                             o_pl.ovf[i] ? 64'hFFFF_FFFF : 64'(dv_q_r[DV_N][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r    <= o_res_nxt;
      out_applied_r <= o_pl.applied;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_applied_r;

endmodule

### test/tb.sv
module tb;
  import fge_pkg::*;

  typedef struct {
    func_t            func;
    logic [2:0][31:0] obj;
    logic [2:0][31:0] pt;
    logic [2:0][31:0] frc;
    logic [30:0]      span;
    logic [30:0]      k;
  } gen_beat_t;

  typedef struct {
    logic [2:0][31:0] delta;
    logic             applied;
  } force_res_t;

  localparam int STALL_LIMIT = 5000;
  localparam int RAND_ITEMS  = 1600;

  // Holds predicted force contributions in arrival order
  class force_scoreboard;
    force_res_t pending_q[$];
    int         errors;

    function logic [31:0] clamp32(input logic neg, input logic [63:0] m);
      logic [63:0] c;
      if (neg) begin
        c = (m > 64'h8000_0000) ? 64'h8000_0000 : m;
        return 32'(64'd0 - c);
      end
      return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function logic [33:0] isqrt(input logic [67:0] n);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (34'd1 << b);
        if (({34'd0, c} * {34'd0, c}) <= n) r = c;
      end
      return r;
    endfunction

    function force_res_t eval_force(input gen_beat_t g);
      force_res_t           r;
      logic signed [33:0]   d [3];
      logic [32:0]          dm [3];
      logic [31:0]          fm;
      logic [67:0]          s2;
      logic [33:0]          root_v;
      logic [63:0]          left, sk, den, q;
      logic [127:0]         num, q128;
      logic                 sneg;
      logic [63:0]          smag;
      r.delta = '0;
      r.applied = 1'b0;
      s2 = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 34'(signed'(g.obj[i])) - 34'(signed'(g.pt[i]));
        dm[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
        s2 += {35'd0, dm[i]} * {35'd0, dm[i]};
      end
      case (g.func)
        FN_CONST: begin
          r.delta = g.frc;
          r.applied = 1'b1;
        end
        FN_RADIAL: begin
          if (g.span != 0 && s2 <= {37'd0, g.span} * {37'd0, g.span}) begin
            root_v = isqrt(s2);
            left = 64'(g.span) - 64'(root_v);
            for (int i = 0; i < 3; i++) begin
              fm = g.frc[i][31] ? 32'(-g.frc[i]) : g.frc[i];
              r.delta[i] = clamp32(g.frc[i][31], (64'(fm) * left) / 64'(g.span));
            end
            r.applied = 1'b1;
          end
        end
        FN_SPRING: begin
          for (int i = 0; i < 3; i++)
            r.delta[i] = clamp32(d[i] > 0, (64'(dm[i]) * 64'(g.k)) >> FRAC_BITS);
          r.applied = 1'b1;
        end
        default: begin
          root_v = isqrt(s2);
          if (root_v != 0) begin
            sneg = root_v < g.span;
            smag = sneg ? 64'(g.span) - 64'(root_v) : 64'(root_v) - 64'(g.span);
            sk = smag * 64'(g.k);  // wraps at 64 bits like the datapath
            den = 64'(root_v) << FRAC_BITS;
            for (int i = 0; i < 3; i++) begin
              num = 128'(dm[i]) * 128'(sk);
              q128 = num / 128'(den);
              q = (q128 >> 64) != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : q128[63:0];
              r.delta[i] = (d[i] == 0 || q == 0) ? 32'd0 : clamp32((d[i] > 0) != sneg, q);
            end
            r.applied = 1'b1;
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(input gen_beat_t g);
      pending_q.push_back(eval_force(g));
    endfunction

    function void check_result(input logic [95:0] data, input logic app);
      force_res_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: delta=%h applied=%b", data, app);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      for (int i = 0; i < 3; i++)
        if (data[32*i +: 32] !== e.delta[i]) begin
          $error("delta[%0d] expected %h actual %h", i, e.delta[i], data[32*i +: 32]);
          errors++;
        end
      if (app !== e.applied) begin
        $error("applied expected %b actual %b", e.applied, app);
        errors++;
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [351:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [95:0]  out_tdata;
  logic         out_tuser;

  force_scoreboard sb;
  bit  calm;
  bit  hold_done;
  int  idle_cnt;
  int  n_sent;

  force_generator_eval_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Unpack an accepted input beat and hand it to the scoreboard; check each result beat
  always @(posedge clk) begin
    gen_beat_t g;
    if (rst_n && in_tvalid && in_tready) begin
      g.func = func_t'(in_tuser);
      for (int i = 0; i < 3; i++) begin
        g.obj[i] = in_tdata[32*i +: 32];
        g.pt[i]  = in_tdata[96 + 32*i +: 32];
        g.frc[i] = in_tdata[192 + 32*i +: 32];
      end
      g.span = in_tdata[318:288];
      g.k    = in_tdata[349:319];
      sb.note_input(g);
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cnt <= 0;
    else if (idle_cnt >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  // Result-side backpressure: random bursts, one long hold-off
  initial begin
    int n;
    out_tready = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (calm) out_tready <= 1'b1;
      else if (!hold_done && n_sent > 400) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (300) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input gen_beat_t g);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= g.func;
    in_tdata  <= {2'b00, g.k, g.span, g.frc, g.pt, g.obj};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  function automatic gen_beat_t make_beat(input func_t f, input logic [2:0][31:0] o,
                                          input logic [2:0][31:0] p,
                                          input logic [2:0][31:0] fr,
                                          input logic [30:0] sp, input logic [30:0] k);
    gen_beat_t g;
    g.func = f; g.obj = o; g.pt = p; g.frc = fr; g.span = sp; g.k = k;
    return g;
  endfunction

  function automatic gen_beat_t rand_beat();
    gen_beat_t g;
    int sh;
    g.func = func_t'($urandom_range(0, 3));
    sh = $urandom_range(4, 31);
    for (int i = 0; i < 3; i++) begin
      g.pt[i]  = $urandom();
      g.frc[i] = $urandom();
      // mostly nearby objects so range and rest-length cases are reached
      if ($urandom_range(0, 3) != 0)
        g.obj[i] = g.pt[i] + 32'(signed'($urandom()) >>> (32 - sh));
      else
        g.obj[i] = $urandom();
    end
    g.span = ($urandom_range(0, 1) != 0) ? 31'($urandom()) : 31'($urandom() >> (32 - sh));
    g.k    = ($urandom_range(0, 2) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
    if ($urandom_range(0, 30) == 0) g.span = '0;
    return g;
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;

  initial begin
    logic [2:0][31:0] z3, mx3, mn3, o;
    sb = new();
    calm = 1'b0;
    n_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FN_CONST;
    z3 = '0;
    mx3 = {MAXP, MAXP, MAXP};
    mn3 = {MINN, MINN, MINN};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pass-through, field extremes
    send_beat(make_beat(FN_CONST, mx3, mn3, mx3, '1, '1));
    send_beat(make_beat(FN_CONST, mn3, mx3, mn3, '0, '0));
    // radial: zero range, coincident, boundary 3-4-5, out of range
    send_beat(make_beat(FN_RADIAL, z3, z3, mx3, '0, ONE));
    send_beat(make_beat(FN_RADIAL, z3, z3, mn3, 31'(5 * ONE), ONE));
    o = {32'd0, 32'(4 * ONE), 32'(3 * ONE)};
    send_beat(make_beat(FN_RADIAL, o, z3, mx3, 31'(5 * ONE), ONE));
    send_beat(make_beat(FN_RADIAL, o, z3, mx3, 31'(5 * ONE - 1), ONE));
    send_beat(make_beat(FN_RADIAL, mx3, mn3, mx3, '1, '1));
    send_beat(make_beat(FN_RADIAL, o, z3, {MINN, MAXP, 32'h1234_5678}, '1, '0));
    // plain spring: zero offset, widest offsets both ways
    send_beat(make_beat(FN_SPRING, mx3, mx3, z3, '0, '1));
    send_beat(make_beat(FN_SPRING, mx3, mn3, z3, '0, '1));
    send_beat(make_beat(FN_SPRING, mn3, mx3, z3, '0, '1));
    send_beat(make_beat(FN_SPRING, o, z3, z3, '0, 31'(ONE)));
    // anchored: zero offset, at rest length, stretched, compressed, saturating
    send_beat(make_beat(FN_ANCHOR, o, o, z3, 31'(ONE), '1));
    send_beat(make_beat(FN_ANCHOR, o, z3, z3, 31'(5 * ONE), '1));
    send_beat(make_beat(FN_ANCHOR, o, z3, z3, 31'(ONE), 31'(2 * ONE)));
    send_beat(make_beat(FN_ANCHOR, o, z3, z3, '1, 31'(ONE)));
    send_beat(make_beat(FN_ANCHOR, mx3, mn3, z3, '0, '1));
    send_beat(make_beat(FN_ANCHOR, mn3, mx3, z3, '1, '1));
    send_beat(make_beat(FN_ANCHOR, {32'd0, 32'd0, 32'd1}, z3, z3, '0, 31'(ONE)));

    // Random phase; the last stretch runs without idling
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - 200) calm = 1'b1;
      send_beat(rand_beat());
    end
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d generator/object pairs over all four kinds with random stalls", n_sent);
    $display("and one long output hold-off; mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
